[src/lru_key_value_cache_core_defines.svh]
// Assertion macros for the LRU key/value cache core.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Check a property on a given clock, disabled while reset is held low.
`define LRUKV_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the core clock and reset.
`define LRUKV_ASSERT(label, prop, msg) \
  `LRUKV_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[src/lrukv_pkg.sv]
// Package for the LRU key/value cache core: command codes, sequencer states
// and the status flags of the rank/compare unit. Depends on nothing.
package lrukv_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } lrukv_state_e;

  typedef struct packed {
    logic key_hit;
    logic is_lru;
  } lrukv_flags_t;

endpackage

[src/lrukv_rank_unit.sv]
// Shared compare and rank-update unit of the LRU key/value cache core.
// Depends on lrukv_pkg for the status flag struct.
module lrukv_rank_unit #(
  parameter int CAPACITY = 16
) (
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_i,
  input  logic [$clog2(CAPACITY + 1)-1:0]                    limit_i,
  input  logic                                               target_i,
  input  logic [31:0]                                        key_rd_i,
  input  logic [31:0]                                        key_req_i,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_o,
  output lrukv_pkg::lrukv_flags_t                            flags_o
);

  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  always_comb begin
    if (target_i) begin
      rank_o = '0;
    end else if (CW'(rank_i) < limit_i) begin
      rank_o = rank_i + RW'(1);
    end else begin
      rank_o = rank_i;
    end
  end

  assign flags_o.key_hit = (key_rd_i == key_req_i);
  assign flags_o.is_lru  = (rank_i == RW'(CAPACITY - 1));

endmodule

[src/lru_key_value_cache_core.sv]
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lrukv_pkg, lrukv_rank_unit and lru_key_value_cache_core_defines.svh.
//
// A command word is taken when start_i is high and busy_o is low; busy_o then
// stays high until the command is done. With F entries held when the command
// is taken, a set or a hitting get makes two passes over them and a missing
// get only the first: one pass walks the key and rank memories one entry per
// cycle to find the key and the least recent entry, and a second pass
// rewrites the rank memory one entry per cycle; each pass ends once its last
// read has returned. A get gives one result word: done_o is high for exactly
// one cycle, the first cycle with busy_o low after the command, with found_o
// and read_value_o valid in that cycle only; the receiver must take it then.
// A set gives no result. Entries fill in index order, so the fill count alone
// marks which entries are valid and no clearing pass runs.
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic        found_o,
  output logic [31:0] read_value_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  lrukv_pkg::lrukv_state_e state_q, state_d;

  logic          cmd_q;
  logic [31:0]   key_q;
  logic [31:0]   val_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [IW-1:0] hit_rank_q, hit_rank_d;
  logic [IW-1:0] lru_idx_q, lru_idx_d;
  logic [IW-1:0] tgt_idx_q, tgt_idx_d;
  logic [CW-1:0] limit_q, limit_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          done_q, done_d;
  logic          found_q, found_d;
  logic [31:0]   rdval_q, rdval_d;

  logic [31:0]   key_mem  [CAPACITY];
  logic [31:0]   val_mem  [CAPACITY];
  logic [IW-1:0] rank_mem [CAPACITY];
  logic [31:0]   key_rd_q;
  logic [31:0]   val_rd_q;
  logic [IW-1:0] rank_rd_q;

  logic          rank_we;
  logic [IW-1:0] rank_waddr;
  logic [IW-1:0] rank_wdata;
  logic          kv_we;
  logic          accept;
  logic          issue;
  logic          pass_done;
  logic          full;

  logic [IW-1:0]           unit_rank;
  lrukv_pkg::lrukv_flags_t unit_flags;

  assign accept    = start_i && !busy_o;
  assign issue     = ((state_q == lrukv_pkg::ST_SCAN) || (state_q == lrukv_pkg::ST_UPDATE))
                     && (cnt_q != fill_q);
  assign pass_done = (cnt_q == fill_q) && !rd_vld_q;
  assign full      = (fill_q == CW'(CAPACITY));

  lrukv_rank_unit #(
    .CAPACITY (CAPACITY)
  ) u_rank_unit (
    .rank_i    (rank_rd_q),
    .limit_i   (limit_q),
    .target_i  (rd_idx_q == tgt_idx_q),
    .key_rd_i  (key_rd_q),
    .key_req_i (key_q),
    .rank_o    (unit_rank),
    .flags_o   (unit_flags)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrukv_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lrukv_pkg::ST_SCAN;
        end
      end
      lrukv_pkg::ST_SCAN: begin
        if (pass_done) begin
          state_d = lrukv_pkg::ST_DECIDE;
        end
      end
      lrukv_pkg::ST_DECIDE: begin
        if ((cmd_q == lrukv_pkg::CMD_GET) && !hit_q) begin
          state_d = lrukv_pkg::ST_FINISH;
        end else begin
          state_d = lrukv_pkg::ST_UPDATE;
        end
      end
      lrukv_pkg::ST_UPDATE: begin
        if (pass_done) begin
          state_d = lrukv_pkg::ST_FINISH;
        end
      end
      lrukv_pkg::ST_FINISH: begin
        state_d = lrukv_pkg::ST_IDLE;
      end
      default: begin
        state_d = lrukv_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls
  always_comb begin
    cnt_d      = issue ? cnt_q + CW'(1) : cnt_q;
    rd_vld_d   = issue;
    rd_idx_d   = cnt_q[IW-1:0];
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_rank_d = hit_rank_q;
    lru_idx_d  = lru_idx_q;
    tgt_idx_d  = tgt_idx_q;
    limit_d    = limit_q;
    fill_d     = fill_q;
    done_d     = 1'b0;
    found_d    = 1'b0;
    rdval_d    = '0;
    rank_we    = 1'b0;
    rank_waddr = rd_idx_q;
    rank_wdata = unit_rank;
    kv_we      = 1'b0;
    case (state_q)
      lrukv_pkg::ST_IDLE: begin
        cnt_d = '0;
        hit_d = 1'b0;
      end
      lrukv_pkg::ST_SCAN: begin
        if (rd_vld_q && unit_flags.key_hit) begin
          hit_d      = 1'b1;
          hit_idx_d  = rd_idx_q;
          hit_rank_d = rank_rd_q;
        end
        if (rd_vld_q && unit_flags.is_lru) begin
          lru_idx_d = rd_idx_q;
        end
      end
      lrukv_pkg::ST_DECIDE: begin
        cnt_d = '0;
        if (hit_q) begin
          tgt_idx_d = hit_idx_q;
          limit_d   = CW'(hit_rank_q);
        end else if (!full) begin
          tgt_idx_d = fill_q[IW-1:0];
          limit_d   = fill_q;
        end else begin
          tgt_idx_d = lru_idx_q;
          limit_d   = CW'(CAPACITY - 1);
        end
      end
      lrukv_pkg::ST_UPDATE: begin
        rank_we = rd_vld_q;
      end
      lrukv_pkg::ST_FINISH: begin
        rank_waddr = tgt_idx_q;
        rank_wdata = '0;
        rank_we    = (cmd_q == lrukv_pkg::CMD_SET) || hit_q;
        if (cmd_q == lrukv_pkg::CMD_SET) begin
          kv_we = 1'b1;
          if (!hit_q && !full) begin
            fill_d = fill_q + CW'(1);
          end
        end else begin
          done_d  = 1'b1;
          found_d = hit_q;
          rdval_d = hit_q ? val_rd_q : '0;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lrukv_pkg::ST_IDLE;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      fill_q     <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      hit_q      <= hit_d;
      fill_q     <= fill_d;
      done_q     <= done_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    lru_idx_q  <= lru_idx_d;
    tgt_idx_q  <= tgt_idx_d;
    limit_q    <= limit_d;
    rdval_q    <= rdval_d;
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[tgt_idx_q] <= key_q;
    end
    key_rd_q <= key_mem[cnt_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      val_mem[tgt_idx_q] <= val_q;
    end
    val_rd_q <= val_mem[tgt_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rd_q <= rank_mem[cnt_q[IW-1:0]];
  end

  assign busy_o       = (state_q != lrukv_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign found_o      = found_q;
  assign read_value_o = rdval_q;

  `LRUKV_ASSERT(a_done_after_get, done_o |-> ($past(state_q) == lrukv_pkg::ST_FINISH) && ($past(cmd_q) == lrukv_pkg::CMD_GET), "result word without a finished get")
  `LRUKV_ASSERT(a_fill_bound, fill_q <= CW'(CAPACITY), "fill count beyond capacity")
  `LRUKV_ASSERT(a_found_strobed, found_o |-> done_o, "found flag outside a result word")
  `LRUKV_ASSERT(a_miss_zero, (done_o && !found_o) |-> (read_value_o == '0), "nonzero value on a miss")
  `LRUKV_ASSERT(a_busy_after_start, accept |=> busy_o, "command taken but core not busy")

endmodule
